// ===== design/mlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlbd_pkg
// Shared constants and register codes of the mip level box downsampler.
// ----------------------------------------------------------------------------
package mlbd_pkg;

  // fixed port widths
  localparam int PIX_W = 16;
  localparam int CFG_W = 11;
  localparam int CFG_INDEX_W = 1;

  // parameter defaults
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_CHANNEL_BITS = 16;

  // register reset values
  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = CFG_W'(256);
  localparam logic FILTER_ENABLE_RESET = 1'b1;

  // smallest line the counters handle
  localparam int MIN_WIDTH = 2;

  // rounding bias of the four-pixel average
  localparam int ROUND_BIAS = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = CFG_INDEX_W'(1);

endpackage

// ===== design/mlbd_ram.sv =====
// ----------------------------------------------------------------------------
// mlbd_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mlbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/mlbd_avg.sv =====
// ----------------------------------------------------------------------------
// mlbd_avg
// One channel of the output: rounded 2x2 average or the stored top-left value.
// ----------------------------------------------------------------------------
module mlbd_avg
  import mlbd_pkg::*;
#(
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic                    filter,
  input  logic [CHANNEL_BITS:0]   stored,
  input  logic [CHANNEL_BITS-1:0] held,
  input  logic [CHANNEL_BITS-1:0] pixel,
  output logic [CHANNEL_BITS-1:0] result
);

  localparam int SUM_W = CHANNEL_BITS + 3;

  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(stored) + SUM_W'(held) + SUM_W'(pixel) + SUM_W'(ROUND_BIAS);

  always_comb begin
    if (filter) begin
      result = sum[CHANNEL_BITS+1:2];
    end else begin
      result = stored[CHANNEL_BITS-1:0];
    end
  end

endmodule

// ===== design/mip_level_box_downsample_core.sv =====
// ----------------------------------------------------------------------------
// mip_level_box_downsample_core
// 2x2 box filter / point downsampler for a raster stream of 4-channel pixels.
// ----------------------------------------------------------------------------
// Input channel: one pixel per request (in_valid / in_stall), rows of
// line_width pixels (made even, MIN_WIDTH..MAX_WIDTH); start_of_image
// realigns the row and column counters. Even rows write pair sums (or the
// left pixel) into a half-width line buffer; on odd rows every odd column
// gives one output pixel on the output channel (out_valid / out_stall),
// image_done marking the one caused by last_pixel.
// Throughput: one input pixel per clock while in_stall is low; the single
// line buffer port is read or written once per pixel pair (odd column).
// An output is registered in the read stage (line buffer read at the
// accepting edge), then in the output register, where it can be taken; a
// full output register holds it in the read stage.
// Reset clears counters, held pixel and pipeline valid bits and loads
// line_width = 256, filter_enable = 1; line buffer contents are undefined
// until the first even row writes them; no clearing pass is needed.
// When the receiver stalls, the output register holds, one further result
// waits in the read stage, and in_stall rises only when both are full.
// Configuration writes are taken at any cycle and must be done while idle.
// ----------------------------------------------------------------------------
module mip_level_box_downsample_core
  import mlbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIX_W-1:0]       channel_0,
  input  logic [PIX_W-1:0]       channel_1,
  input  logic [PIX_W-1:0]       channel_2,
  input  logic [PIX_W-1:0]       channel_3,
  input  logic                   start_of_image,
  input  logic                   last_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIX_W-1:0]       out_channel_0,
  output logic [PIX_W-1:0]       out_channel_1,
  output logic [PIX_W-1:0]       out_channel_2,
  output logic [PIX_W-1:0]       out_channel_3,
  output logic                   image_done
);

  localparam int NCH = 4;
  localparam int HALF_DEPTH = MAX_WIDTH / 2;
  localparam int AW = $clog2(HALF_DEPTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;
  localparam int SW = CHANNEL_BITS + 1;
  localparam int RAM_W = NCH * SW;

  // configuration
  logic [CFG_W-1:0] line_width;
  logic             filter_enable;

  // counters and held pixel
  logic [CW-1:0]           column_count;
  logic                    odd_row;
  logic [CHANNEL_BITS-1:0] held [NCH];

  // read stage
  logic                    s1_valid;
  logic                    s1_done;
  logic [CHANNEL_BITS-1:0] s1_held [NCH];
  logic [CHANNEL_BITS-1:0] s1_px [NCH];

  logic [CHANNEL_BITS-1:0] px [NCH];
  logic [CHANNEL_BITS-1:0] avg [NCH];
  logic [EW-1:0]           lw_even;
  logic [EW-1:0]           eff_width;
  logic [CW-1:0]           col_cur;
  logic                    odd_cur;
  logic [CW-1:0]           col_plus;
  logic [CW-2:0]           idx_full;
  logic [AW-1:0]           addr;
  logic                    in_acc;
  logic                    s1_advance;
  logic                    ram_we;
  logic                    ram_re;
  logic [RAM_W-1:0]        ram_wdata;
  logic [RAM_W-1:0]        ram_rdata;

  assign px[0] = channel_0[CHANNEL_BITS-1:0];
  assign px[1] = channel_1[CHANNEL_BITS-1:0];
  assign px[2] = channel_2[CHANNEL_BITS-1:0];
  assign px[3] = channel_3[CHANNEL_BITS-1:0];

  // handshake
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_acc = in_valid && !in_stall;

  // effective line width: even, at least MIN_WIDTH, limited to the buffer size
  assign lw_even = EW'({line_width[CFG_W-1:1], 1'b0});
  always_comb begin
    if (lw_even < EW'(MIN_WIDTH)) begin
      eff_width = EW'(MIN_WIDTH);
    end else if (lw_even > EW'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = lw_even;
    end
  end

  assign col_cur = start_of_image ? '0 : column_count;
  assign odd_cur = start_of_image ? 1'b0 : odd_row;
  assign col_plus = col_cur + CW'(1);

  // line buffer index wraps only at an odd maximum width
  assign idx_full = col_cur[CW-1:1];
  assign addr = (idx_full == (CW-1)'(HALF_DEPTH)) ? '0 : idx_full[AW-1:0];

  assign ram_we = in_acc && col_cur[0] && !odd_cur;
  assign ram_re = in_acc && col_cur[0] && odd_cur;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (filter_enable) begin
        ram_wdata[c*SW +: SW] = SW'(held[c]) + SW'(px[c]);
      end else begin
        ram_wdata[c*SW +: SW] = SW'(held[c]);
      end
    end
  end

  mlbd_ram #(
    .WIDTH(RAM_W),
    .DEPTH(HALF_DEPTH)
  ) u_line_buf (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  for (genvar g = 0; g < NCH; g++) begin : g_avg
    mlbd_avg #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_avg (
      .filter(filter_enable),
      .stored(ram_rdata[g*SW +: SW]),
      .held  (s1_held[g]),
      .pixel (s1_px[g]),
      .result(avg[g])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      filter_enable <= FILTER_ENABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:    line_width <= cfg_data;
        REG_FILTER_ENABLE: filter_enable <= cfg_data[0];
      endcase
    end
  end

  // counters and held pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        held[c] <= '0;
      end
    end else if (in_acc) begin
      if (EW'(col_plus) >= eff_width) begin
        column_count <= '0;
        odd_row <= !odd_cur;
      end else begin
        column_count <= col_plus;
        odd_row <= odd_cur;
      end
      if (!col_cur[0]) begin
        held <= px;
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= ram_re;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      s1_held <= held;
      s1_px <= px;
      s1_done <= last_pixel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_channel_0 <= PIX_W'(avg[0]);
      out_channel_1 <= PIX_W'(avg[1]);
      out_channel_2 <= PIX_W'(avg[2]);
      out_channel_3 <= PIX_W'(avg[3]);
      image_done <= s1_done;
    end
  end

endmodule

// ===== test/mlbd_checker.sv =====
// ----------------------------------------------------------------------------
// mlbd_checker
// Watches the pixel channels and register writes of the mip level
// downsampler, predicts each downsampled pixel and compares field by field.
// ----------------------------------------------------------------------------
module mlbd_checker
  import mlbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [PIX_W-1:0]       channel_0,
  input  logic [PIX_W-1:0]       channel_1,
  input  logic [PIX_W-1:0]       channel_2,
  input  logic [PIX_W-1:0]       channel_3,
  input  logic                   start_of_image,
  input  logic                   last_pixel,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [PIX_W-1:0]       out_channel_0,
  input  logic [PIX_W-1:0]       out_channel_1,
  input  logic [PIX_W-1:0]       out_channel_2,
  input  logic [PIX_W-1:0]       out_channel_3,
  input  logic                   image_done,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int HALF_DEPTH = DEF_MAX_WIDTH / 2;
  localparam int STORE_W = DEF_CHANNEL_BITS + 1;

  typedef struct packed {
    logic [3:0][PIX_W-1:0] chan;
    logic                  done;
  } down_px_t;

  logic [CFG_W-1:0]        width_reg;
  logic                    filter_on;
  logic [3:0][PIX_W-1:0]   held_px;
  logic [STORE_W-1:0]      line_store [4][HALF_DEPTH];
  int                      col;
  logic                    odd_line;
  down_px_t                expected_px[$];

  function automatic int line_len();
    int w;
    w = int'(width_reg) & 'h7FE;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  task automatic take_pixel(input logic [3:0][PIX_W-1:0] px, input logic sof,
                            input logic lastp);
    int w, idx, acc;
    down_px_t res;
    w = line_len();
    if (sof) begin
      col = 0;
      odd_line = 1'b0;
    end
    if (col % 2 == 0) begin
      held_px = px;
    end else begin
      idx = (col / 2) % HALF_DEPTH;
      if (!odd_line) begin
        for (int c = 0; c < 4; c++) begin
          acc = filter_on ? int'(held_px[c]) + int'(px[c]) : int'(held_px[c]);
          line_store[c][idx] = STORE_W'(acc);
        end
      end else begin
        // stored value goes in as-is, whatever mode wrote it
        for (int c = 0; c < 4; c++) begin
          acc = int'(line_store[c][idx]);
          if (filter_on)
            acc = (acc + int'(held_px[c]) + int'(px[c]) + ROUND_BIAS) >> 2;
          res.chan[c] = PIX_W'(acc);
        end
        res.done = lastp;
        expected_px.push_back(res);
      end
    end
    col = (col + 1) & 'hFFFF;
    if (col >= w) begin
      col = 0;
      odd_line = ~odd_line;
    end
  endtask

  task automatic check_result();
    down_px_t want;
    logic [3:0][PIX_W-1:0] got;
    got = {out_channel_3, out_channel_2, out_channel_1, out_channel_0};
    if (expected_px.size() == 0) begin
      $error("output pixel with none expected");
      fail_count++;
    end else begin
      want = expected_px.pop_front();
      for (int c = 0; c < 4; c++) begin
        if (got[c] !== want.chan[c]) begin
          $error("out_channel_%0d expected %0d actual %0d", c, want.chan[c], got[c]);
          fail_count++;
        end
      end
      if (image_done !== want.done) begin
        $error("image_done expected %0d actual %0d", want.done, image_done);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = LINE_WIDTH_RESET;
      filter_on = FILTER_ENABLE_RESET;
      held_px = '0;
      col = 0;
      odd_line = 1'b0;
      expected_px.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_we) begin
        if (cfg_index == REG_LINE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_FILTER_ENABLE) filter_on = cfg_data[0];
      end
      if (in_valid && !in_stall)
        take_pixel({channel_3, channel_2, channel_1, channel_0}, start_of_image,
                   last_pixel);
    end
    pending_count = expected_px.size();
  end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the mip level downsampler: directed corner rows, then random
// images over many line widths and both modes, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb
  import mlbd_pkg::*;
();

  localparam int RANDOM_PIXELS = 420;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [PIX_W-1:0]       channel_0;
  logic [PIX_W-1:0]       channel_1;
  logic [PIX_W-1:0]       channel_2;
  logic [PIX_W-1:0]       channel_3;
  logic                   start_of_image;
  logic                   last_pixel;
  logic                   out_valid;
  logic                   out_stall;
  logic [PIX_W-1:0]       out_channel_0;
  logic [PIX_W-1:0]       out_channel_1;
  logic [PIX_W-1:0]       out_channel_2;
  logic [PIX_W-1:0]       out_channel_3;
  logic                   image_done;
  int                     fail_count;
  int                     pending_count;

  bit tx_idle;
  bit rx_idle;
  int random_px;

  mip_level_box_downsample_core dut (.*);
  mlbd_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // output side: random stall before each pixel is taken
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = rx_idle ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [PIX_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_pixel(input logic [3:0][PIX_W-1:0] px, input logic sof,
                             input logic lastp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    channel_0 <= px[0];
    channel_1 <= px[1];
    channel_2 <= px[2];
    channel_3 <= px[3];
    start_of_image <= sof;
    last_pixel <= lastp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain: all predicted pixels out, then an idle pause
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic send_image(input int width, input int rows, input bit lead_sof);
    int total, cut;
    logic [3:0][PIX_W-1:0] px;
    logic sof, lastp;
    total = width * rows;
    // now and then an image is broken off early
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
    for (int i = 0; i < cut; i++) begin
      for (int c = 0; c < 4; c++) px[c] = rand_chan();
      if (i == 0) sof = lead_sof || ($urandom_range(0, 15) != 0);
      else sof = ($urandom_range(0, 63) == 0);
      lastp = (i == cut - 1) || ($urandom_range(0, 31) == 0);
      drive_pixel(px, sof, lastp);
      random_px++;
    end
  endtask

  initial begin
    int wval, eff, n_img, rows;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    channel_0 = '0;
    channel_1 = '0;
    channel_2 = '0;
    channel_3 = '0;
    start_of_image = 1'b0;
    last_pixel = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_px = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_LINE_WIDTH, CFG_W'(4));
    write_reg(REG_FILTER_ENABLE, CFG_W'(1));
    // first pair of rows, last_pixel on a pixel that gives no output
    drive_pixel('0, 1'b1, 1'b1);
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel({16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0, 1'b0);
    drive_pixel({16'hFFFE, 16'h0001, 16'h8000, 16'h0000}, 1'b0, 1'b0);
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel('0, 1'b0, 1'b0);
    drive_pixel({4{16'h5555}}, 1'b0, 1'b1);
    // full-scale pair sums, then read back in point mode
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel({16'h1234, 16'hFFFF, 16'h0000, 16'h8001}, 1'b0, 1'b0);
    drive_pixel({16'hEDCB, 16'hFFFF, 16'h0001, 16'h7FFF}, 1'b0, 1'b0);
    settle();
    write_reg(REG_FILTER_ENABLE, CFG_W'(0));
    drive_pixel({16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h0000}, 1'b0, 1'b0);
    drive_pixel('0, 1'b0, 1'b0);
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel({4{16'h00FF}}, 1'b0, 1'b1);
    // point-mode row cut short by a narrower line, averaged on the next row
    drive_pixel({16'h4000, 16'hC000, 16'h0003, 16'hFFFC}, 1'b0, 1'b0);
    drive_pixel('1, 1'b0, 1'b0);
    drive_pixel({4{16'h1111}}, 1'b0, 1'b0);
    settle();
    write_reg(REG_LINE_WIDTH, CFG_W'(2));
    write_reg(REG_FILTER_ENABLE, CFG_W'(1));
    drive_pixel({4{16'h2222}}, 1'b0, 1'b0);
    drive_pixel({16'hFFFF, 16'h0000, 16'h8000, 16'h0001}, 1'b0, 1'b0);
    drive_pixel({16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0002}, 1'b0, 1'b1);

    while (random_px < RANDOM_PIXELS) begin
      settle();
      case ($urandom_range(0, 7))
        0: wval = 0;
        1: wval = 1;
        2: wval = 2;
        3: wval = $urandom_range(3, 15) | 1;
        default: wval = $urandom_range(2, 16);
      endcase
      write_reg(REG_LINE_WIDTH, CFG_W'(wval));
      write_reg(REG_FILTER_ENABLE, CFG_W'($urandom_range(0, 1)));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      eff = wval & 'h7FE;
      if (eff < MIN_WIDTH) eff = MIN_WIDTH;
      n_img = $urandom_range(1, 3);
      for (int k = 0; k < n_img; k++) begin
        rows = 2 * $urandom_range(1, 3);
        if ($urandom_range(0, 7) == 0) rows = rows - 1;
        send_image(eff, rows, k == 0);
      end
    end

    settle();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
